FILE: rtl/core/cfs_pkg.sv
// Shared types and constants of the CSV field splitter.
package cfs_pkg;

  localparam int unsigned MaxRes   = 4;
  localparam int unsigned ResIdxW  = $clog2(MaxRes);
  localparam int unsigned ResCntW  = $clog2(MaxRes + 1);
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;

  localparam logic [7:0] QuoteByte  = 8'h22;
  localparam logic [7:0] LfByte     = 8'h0A;
  localparam logic [7:0] CrByte     = 8'h0D;
  localparam logic [7:0] NulByte    = 8'h00;
  localparam logic [7:0] DelimReset = 8'd44;
  localparam logic [2:0] MinLen     = 3'd2;

  // register index is the word address, paddr[2]
  localparam logic RegDelimiter = 1'b0;

  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       fend;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0]  res;
    logic [ResCntW-1:0] cnt;
    logic               line_end;
  } pkt_t;

endpackage

FILE: rtl/core/csv_field_splitter_unit.sv
// Top level of the CSV field splitter: registers, splitting logic and result register.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o   | data_byte_i, last_in_line_i
//   out     | output    | out_valid_o / out_stall_i | field_byte_o, byte_valid_o,
//           |           |                         | field_end_o, line_end_o
//   cfg     | APB       | psel, penable, pready     | paddr, pwdata, prdata
//
// One byte per cycle while each byte yields at most one result and output is unstalled;
// results go through the input and result registers. A byte giving n results (up to 4
// on the line's last byte) holds the result register, draining one per unstalled cycle.
// Reset clears line state and sets the delimiter to comma. Output stalls back up
// through the result register into the input register.
module csv_field_splitter_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        last_in_line_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  field_byte_o,
  output logic                        byte_valid_o,
  output logic                        field_end_o,
  output logic                        line_end_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cfs_pkg::PaddrW-1:0]  paddr,
  input  logic [cfs_pkg::PdataW-1:0]  pwdata,
  output logic [cfs_pkg::PdataW-1:0]  prdata,
  output logic                        pready
);
  import cfs_pkg::*;

  logic [7:0] delimiter;
  logic       buf_free;
  logic       pkt_load;
  pkt_t       pkt;

  cfs_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .delimiter_o (delimiter)
  );

  cfs_split u_split (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_in_line_i (last_in_line_i),
    .delimiter_i    (delimiter),
    .buf_free_i     (buf_free),
    .pkt_load_o     (pkt_load),
    .pkt_o          (pkt)
  );

  cfs_res_buf u_res_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pkt_load_i   (pkt_load),
    .pkt_i        (pkt),
    .buf_free_o   (buf_free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .field_byte_o (field_byte_o),
    .byte_valid_o (byte_valid_o),
    .field_end_o  (field_end_o),
    .line_end_o   (line_end_o)
  );

endmodule

FILE: rtl/core/cfs_apb_regs.sv
// APB register block holding the field delimiter.
module cfs_apb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cfs_pkg::PaddrW-1:0]  paddr,
  input  logic [cfs_pkg::PdataW-1:0]  pwdata,
  output logic [cfs_pkg::PdataW-1:0]  prdata,
  output logic                        pready,
  output logic [7:0]                  delimiter_o
);
  import cfs_pkg::*;

  logic [7:0] delim_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegDelimiter);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DelimReset;
    end else if (wr_en) begin
      delim_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegDelimiter) begin
      prdata = {{(PdataW-8){1'b0}}, delim_q};
    end
  end

  assign delimiter_o = delim_q;

endmodule

FILE: rtl/core/cfs_split.sv
// Input register, line state and the per-byte splitting logic.
module cfs_split (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_in_line_i,
  input  logic [7:0]         delimiter_i,
  input  logic               buf_free_i,
  output logic               pkt_load_o,
  output cfs_pkg::pkt_t      pkt_o
);
  import cfs_pkg::*;

  typedef struct packed {
    pkt_t pkt;
    logic iq;
    logic two;
    logic lf_end;
  } step_t;

  function automatic pkt_t push(pkt_t p, logic [7:0] b, logic v, logic f);
    pkt_t r;
    r = p;
    if (r.cnt < ResCntW'(MaxRes)) begin
      r.res[r.cnt[ResIdxW-1:0]] = '{data: b, vld: v, fend: f};
      r.cnt = r.cnt + 1'b1;
    end
    return r;
  endfunction

  function automatic step_t do_byte(pkt_t p, logic iq, logic [7:0] b, logic has_n,
                                    logic [7:0] n, logic has_nn, logic [7:0] nn,
                                    logic [7:0] delim);
    step_t s;
    s.pkt    = p;
    s.iq     = iq;
    s.two    = 1'b0;
    s.lf_end = 1'b0;
    if (!iq && (b == delim || b == LfByte)) begin
      s.pkt    = push(p, NulByte, 1'b0, 1'b1);
      s.lf_end = (b != delim);
    end else if (b == QuoteByte) begin
      if (has_n && n == QuoteByte) begin
        if (iq || (has_nn && nn != delim)) begin
          s.pkt = push(p, QuoteByte, 1'b1, 1'b0);
        end
        s.two = 1'b1;
      end else begin
        s.iq = !iq;
      end
    end else begin
      s.pkt = push(p, b, 1'b1, 1'b0);
    end
    return s;
  endfunction

  // input register
  logic       s0_valid_q;
  logic [7:0] s0_byte_q;
  logic       s0_last_q;
  logic       advance;
  logic       accept;

  // line state
  logic       iq_q, iq_d;
  logic [7:0] la0_q, la0_d, la1_q, la1_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] seen_q, seen_d;
  logic       hq_q, hq_d;

  pkt_t       pkt;
  step_t      st;
  logic       two;
  logic       skip;
  logic       lf_end;
  logic       iqv;
  logic [7:0] rem [5];
  logic [2:0] rlen;
  logic [2:0] seen_sum;

  always_comb begin
    pkt      = '0;
    st       = '0;
    two      = 1'b0;
    skip     = 1'b0;
    lf_end   = 1'b0;
    iqv      = iq_q;
    rlen     = '0;
    seen_sum = '0;
    iq_d     = iq_q;
    la0_d    = la0_q;
    la1_d    = la1_q;
    cnt_d    = cnt_q;
    seen_d   = seen_q;
    hq_d     = hq_q;
    for (int i = 0; i < 5; i++) begin
      rem[i] = NulByte;
    end

    if (!s0_last_q) begin
      if (hq_q && cnt_q != 2'd0) begin
        if (la0_q != delimiter_i) begin
          pkt = push(pkt, QuoteByte, 1'b1, 1'b0);
        end
        hq_d = 1'b0;
      end
      if (cnt_q < 2'd2) begin
        if (cnt_q == 2'd0) begin
          la0_d = s0_byte_q;
        end else begin
          la1_d = s0_byte_q;
        end
        cnt_d = cnt_q + 2'd1;
      end else begin
        if (!iq_q && la0_q != delimiter_i && la0_q == QuoteByte && la1_q == QuoteByte &&
            s0_byte_q == CrByte) begin
          hq_d = 1'b1;
          two  = 1'b1;
        end else begin
          st   = do_byte(pkt, iq_q, la0_q, 1'b1, la1_q, 1'b1, s0_byte_q, delimiter_i);
          pkt  = st.pkt;
          iq_d = st.iq;
          two  = st.two;
        end
        seen_sum = {1'b0, seen_q} + (two ? 3'd2 : 3'd1);
        seen_d   = (seen_sum > 3'd2) ? 2'd2 : seen_sum[1:0];
        if (two) begin
          la0_d = s0_byte_q;
          la1_d = NulByte;
          cnt_d = 2'd1;
        end else begin
          la0_d = la1_q;
          la1_d = s0_byte_q;
          cnt_d = 2'd2;
        end
      end
    end else begin
      if (cnt_q == 2'd0) begin
        rem[0] = s0_byte_q;
        rlen   = 3'd1;
      end else if (cnt_q == 2'd1) begin
        rem[0] = la0_q;
        rem[1] = s0_byte_q;
        rlen   = 3'd2;
      end else begin
        rem[0] = la0_q;
        rem[1] = la1_q;
        rem[2] = s0_byte_q;
        rlen   = 3'd3;
      end
      if (s0_byte_q == LfByte) begin
        rlen = rlen - 3'd1;
        if (rlen != 3'd0 && rem[rlen[1:0] - 2'd1] == CrByte) begin
          rlen = rlen - 3'd1;
        end
      end
      if (!(seen_q == 2'd0 && !hq_q && rlen < MinLen)) begin
        if (hq_q && rlen != 3'd0 && rem[0] != delimiter_i) begin
          pkt = push(pkt, QuoteByte, 1'b1, 1'b0);
        end
        for (int j = 0; j < 3; j++) begin
          if (skip) begin
            skip = 1'b0;
          end else if (3'(j) < rlen) begin
            st = do_byte(pkt, iqv, rem[j], 3'(j + 1) < rlen, rem[j + 1],
                         3'(j + 2) < rlen, rem[j + 2], delimiter_i);
            pkt    = st.pkt;
            iqv    = st.iq;
            lf_end = st.lf_end;
            skip   = st.two;
          end
        end
        if (!lf_end) begin
          pkt = push(pkt, NulByte, 1'b0, 1'b1);
        end
        pkt.line_end = 1'b1;
      end
      iq_d   = 1'b0;
      la0_d  = NulByte;
      la1_d  = NulByte;
      cnt_d  = 2'd0;
      seen_d = 2'd0;
      hq_d   = 1'b0;
    end
  end

  assign advance    = s0_valid_q && (buf_free_i || pkt.cnt == '0);
  assign in_stall_o = s0_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign pkt_load_o = advance && pkt.cnt != '0;
  assign pkt_o      = pkt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (accept) begin
      s0_valid_q <= 1'b1;
    end else if (advance) begin
      s0_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_byte_q <= data_byte_i;
      s0_last_q <= last_in_line_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iq_q   <= 1'b0;
      la0_q  <= '0;
      la1_q  <= '0;
      cnt_q  <= '0;
      seen_q <= '0;
      hq_q   <= 1'b0;
    end else if (advance) begin
      iq_q   <= iq_d;
      la0_q  <= la0_d;
      la1_q  <= la1_d;
      cnt_q  <= cnt_d;
      seen_q <= seen_d;
      hq_q   <= hq_d;
    end
  end

endmodule

FILE: rtl/core/cfs_res_buf.sv
// Result register: holds one item's results and hands them out one per beat.
module cfs_res_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pkt_load_i,
  input  cfs_pkg::pkt_t pkt_i,
  output logic          buf_free_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    field_byte_o,
  output logic          byte_valid_o,
  output logic          field_end_o,
  output logic          line_end_o
);
  import cfs_pkg::*;

  res_t [MaxRes-1:0]  res_q;
  logic [ResCntW-1:0] cnt_q;
  logic [ResIdxW-1:0] idx_q;
  logic               line_q;
  logic               busy_q;
  logic               take;
  logic               at_last;

  assign at_last    = ({1'b0, idx_q} == (cnt_q - 1'b1));
  assign take       = busy_q && !out_stall_i;
  assign buf_free_o = !busy_q || (take && at_last);

  assign out_valid_o  = busy_q;
  assign field_byte_o = res_q[idx_q].data;
  assign byte_valid_o = res_q[idx_q].vld;
  assign field_end_o  = res_q[idx_q].fend;
  assign line_end_o   = line_q && at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pkt_load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (take && at_last) begin
      busy_q <= 1'b0;
    end else if (take) begin
      idx_q  <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_load_i) begin
      res_q  <= pkt_i.res;
      cnt_q  <= pkt_i.cnt;
      line_q <= pkt_i.line_end;
    end
  end

endmodule
